// File: sv/kvs_pkg.sv
// Package: shared types, constants and state codes of the keyframe sampler.
package kvs_pkg;
  localparam int MaxKeys = 64;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = IdxW + 1;

  typedef enum logic [0:0] {
    KindLoad  = 1'b0,
    KindQuery = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    RegKeyCount = 1'b0,
    RegStepMode = 1'b1
  } reg_e;

  typedef struct packed {
    logic        kind;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [5:0]  lower_key;
    logic [15:0] blend_fraction;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StSearch,
    StSearchWait,
    StBracket,
    StBracketWait,
    StTimes,
    StDivide,
    StLowRead,
    StLowWait,
    StHighRead,
    StHighWait,
    StMul,
    StDone
  } state_e;

  typedef enum logic [1:0] {
    RdSearch,
    RdLow,
    RdHigh
  } rdsel_e;

  typedef struct packed {
    logic   load_query;
    logic   mem_rd;
    rdsel_e rd_sel;
    logic   search_step;
    logic   cap_t0;
    logic   cap_t1;
    logic   div_start;
    logic   div_step;
    logic   cap_low;
    logic   cap_high;
    logic   mul_step;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic need_div;
    logic div_done;
    logic need_high;
    logic mul_done;
  } dp_sts_t;
endpackage

// File: sv/kvs_ctrl.sv
// Controller: sequences search, division and blending for one query.
module kvs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             query_i,
  input  kvs_pkg::dp_sts_t sts_i,
  output kvs_pkg::dp_cmd_t cmd_o,
  output logic             busy_o
);
  import kvs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_sel = RdSearch;
    busy_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (query_i) begin
          cmd_o.load_query = 1'b1;
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (sts_i.search_done) begin
          state_d = StBracket;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = StSearchWait;
        end
      end
      StSearchWait: begin
        cmd_o.search_step = 1'b1;
        state_d = StSearch;
      end
      StBracket: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = RdLow;
        state_d = StBracketWait;
      end
      StBracketWait: begin
        cmd_o.cap_t0 = 1'b1;
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = RdHigh;
        state_d = StTimes;
      end
      StTimes: begin
        cmd_o.cap_t1 = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = StDivide;
      end
      StDivide: begin
        if (!sts_i.need_div || sts_i.div_done) begin
          state_d = StLowRead;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StLowRead: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = RdLow;
        state_d = StLowWait;
      end
      StLowWait: begin
        cmd_o.cap_low = 1'b1;
        state_d = sts_i.need_high ? StHighRead : StDone;
      end
      StHighRead: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = RdHigh;
        state_d = StHighWait;
      end
      StHighWait: begin
        cmd_o.cap_high = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        if (sts_i.mul_done) begin
          state_d = StDone;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// File: sv/kvs_datapath.sv
// Datapath: key tables, search registers, serial divider and blend multiplier.
module kvs_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  kvs_pkg::in_item_t         item_i,
  input  logic [kvs_pkg::CntW-1:0]  key_count_i,
  input  logic                      step_mode_i,
  input  kvs_pkg::dp_cmd_t          cmd_i,
  output kvs_pkg::dp_sts_t          sts_o,
  output logic                      valid_o,
  output kvs_pkg::out_item_t        result_o
);
  import kvs_pkg::*;

  logic [31:0]  time_mem [MaxKeys];
  logic [95:0]  val_mem  [MaxKeys];
  logic [31:0]  rd_time_q;
  logic [95:0]  rd_val_q;
  logic [IdxW-1:0] rd_addr;

  logic [31:0]     qt_q;
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] lo_q, cnt_q;
  logic [CntW-1:0] half, probe;
  logic [IdxW-1:0] lidx_q;
  logic            interp_q;
  logic [31:0]     t0_q, den_q;
  logic [47:0]     num_q;
  logic [32:0]     rem_q;
  logic [16:0]     quo_q;
  logic [5:0]      dcnt_q;
  logic            need_div_q;
  logic [15:0]     f_q;
  logic [95:0]     a_q, b_q;
  logic [1:0]      mcnt_q;
  logic [95:0]     acc_q;
  logic            valid_q;
  out_item_t       res_q;

  logic [CntW-1:0] hi_pos, n_eff;
  logic [32:0]     rem_sh, rem_sub;
  logic [15:0]     f_eff;
  logic [31:0]     ma, mb;
  logic signed [32:0] mdiff;
  logic signed [49:0] mprod;
  logic [63:0]     blend_s;

  assign half  = cnt_q >> 1;
  assign probe = lo_q + half;
  assign hi_pos = lo_q;
  assign n_eff = (key_count_i > CntW'(MaxKeys)) ? CntW'(MaxKeys) : key_count_i;

  always_comb begin
    case (cmd_i.rd_sel)
      RdSearch: rd_addr = probe[IdxW-1:0];
      RdLow:    rd_addr = lidx_q;
      RdHigh:   rd_addr = IdxW'(lidx_q + 1'b1);
      default:  rd_addr = lidx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      time_mem[item_i.key_index[IdxW-1:0]] <= item_i.key_time;
      val_mem[item_i.key_index[IdxW-1:0]]  <= {item_i.key_x, item_i.key_y, item_i.key_z};
    end
    if (cmd_i.mem_rd) begin
      rd_time_q <= time_mem[rd_addr];
      rd_val_q  <= val_mem[rd_addr];
    end
  end

  assign rem_sh  = {rem_q[31:0], num_q[47]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign f_eff = step_mode_i ? 16'd0 : f_q;
  always_comb begin
    case (mcnt_q)
      2'd0:    begin ma = a_q[95:64]; mb = b_q[95:64]; end
      2'd1:    begin ma = a_q[63:32]; mb = b_q[63:32]; end
      default: begin ma = a_q[31:0];  mb = b_q[31:0];  end
    endcase
    mdiff   = 33'(signed'(mb)) - 33'(signed'(ma));
    mprod   = mdiff * signed'({1'b0, f_eff});
    blend_s = (64'(signed'(ma)) <<< 16) + 64'(mprod);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      qt_q  <= item_i.query_time;
      n_q   <= n_eff;
      lo_q  <= '0;
      cnt_q <= n_eff;
      f_q   <= '0;
      mcnt_q <= '0;
    end
    if (cmd_i.search_step) begin
      if (!(qt_q < rd_time_q)) begin
        lo_q  <= probe + 1'b1;
        cnt_q <= cnt_q - half - 1'b1;
      end else begin
        cnt_q <= half;
      end
    end
    if (sts_o.search_done && !cmd_i.mem_rd && !cmd_i.cap_t0 && !cmd_i.cap_t1 &&
        !cmd_i.div_step && !cmd_i.cap_low && !cmd_i.cap_high && !cmd_i.mul_step &&
        !cmd_i.emit && !cmd_i.div_start) begin
      if (n_q < 2 || hi_pos == 0) begin
        lidx_q <= '0;
        interp_q <= 1'b0;
      end else if (hi_pos >= n_q) begin
        lidx_q <= IdxW'(n_q - 1'b1);
        interp_q <= 1'b0;
      end else begin
        lidx_q <= IdxW'(hi_pos - 1'b1);
        interp_q <= 1'b1;
      end
    end
    if (cmd_i.cap_t0) begin
      t0_q <= rd_time_q;
    end
    if (cmd_i.div_start) begin
      den_q <= rd_time_q - t0_q;
      num_q <= {qt_q - t0_q, 16'd0};
      rem_q <= '0;
      quo_q <= '0;
      dcnt_q <= '0;
      need_div_q <= interp_q && (rd_time_q > t0_q) && (qt_q >= t0_q);
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      dcnt_q <= dcnt_q + 1'b1;
      if (!rem_sub[32]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[15:0], 1'b1} | {quo_q[16], 16'd0};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[15:0], 1'b0} | {quo_q[16], 16'd0};
      end
      if (dcnt_q == 6'd47) begin
        if (quo_q[16] || quo_q[15]) begin
          f_q <= 16'hFFFF;
        end else begin
          f_q <= {quo_q[14:0], !rem_sub[32]};
        end
      end
    end
    if (cmd_i.cap_low) begin
      a_q <= rd_val_q;
    end
    if (cmd_i.cap_high) begin
      b_q <= rd_val_q;
    end
    if (cmd_i.mul_step) begin
      mcnt_q <= mcnt_q + 1'b1;
      acc_q <= {acc_q[63:0], blend_s[47:16]};
    end
    if (cmd_i.emit) begin
      res_q.lower_key <= lidx_q;
      res_q.blend_fraction <= f_q;
      if (n_q == 0) begin
        res_q.out_x <= '0;
        res_q.out_y <= '0;
        res_q.out_z <= '0;
      end else if (sts_o.need_high) begin
        res_q.out_x <= acc_q[95:64];
        res_q.out_y <= acc_q[63:32];
        res_q.out_z <= acc_q[31:0];
      end else begin
        res_q.out_x <= a_q[95:64];
        res_q.out_y <= a_q[63:32];
        res_q.out_z <= a_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign sts_o.search_done = (cnt_q == '0);
  assign sts_o.need_div    = need_div_q;
  assign sts_o.div_done    = (dcnt_q == 6'd48);
  assign sts_o.need_high   = interp_q && !step_mode_i;
  assign sts_o.mul_done    = (mcnt_q == 2'd3);
  assign valid_o  = valid_q;
  assign result_o = res_q;
endmodule

// File: sv/keyframe_vec3_sampler.sv
// Top level: keyframe table sampler with linear interpolation.
//  channel  | handshake              | payload
//  input    | start / busy           | item_i   (in_item_t)
//  config   | cfg_valid / cfg_ready  | cfg_index_i, cfg_data_i
//  result   | done_o strobe          | result_o (out_item_t)
// A load does not raise busy. A query holds busy through the search probes,
// the divider steps and the multiply steps; the divider steps only when two
// keys bracket the time, and done_o rises in the same cycle in which busy
// drops. Reset clears control state, done_o and the configuration registers;
// the tables hold nothing until loaded. Results cannot stall.
module keyframe_vec3_sampler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  kvs_pkg::in_item_t  item_i,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  output logic               done_o,
  output kvs_pkg::out_item_t result_o
);
  import kvs_pkg::*;

  logic [6:0] key_count_q;
  logic       step_mode_q;
  logic       accept, ctrl_busy;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign busy = ctrl_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      step_mode_q <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_e'(cfg_index_i))
        RegKeyCount: key_count_q <= cfg_data_i;
        RegStepMode: step_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  kvs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (accept && item_i.kind == KindQuery),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  kvs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && item_i.kind == KindLoad),
    .item_i      (item_i),
    .key_count_i (key_count_q),
    .step_mode_i (step_mode_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .valid_o     (done_o),
    .result_o    (result_o)
  );
endmodule

// File: verif/tb.sv
// Testbench for keyframe_vec3_sampler: random key tables and queries checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import kvs_pkg::*;

  localparam int Limit = 2000000;
  localparam int Settle = 120;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start;
  logic       busy;
  in_item_t   item_i;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index_i;
  logic [6:0] cfg_data_i;
  logic       done_o;
  out_item_t  result_o;

  keyframe_vec3_sampler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit [31:0] time_tbl [MaxKeys];
  bit [31:0] x_tbl [MaxKeys];
  bit [31:0] y_tbl [MaxKeys];
  bit [31:0] z_tbl [MaxKeys];
  bit [6:0]  key_count_q;
  bit        step_mode_q;
  bit [31:0] gen_time [MaxKeys];

  in_item_t  pend_q[$];
  out_item_t sample_q[$];
  int        errors;
  longint    cycles;

  function automatic bit [31:0] blend_val(bit [31:0] a, bit [31:0] b, bit [31:0] f);
    longint s;
    s = longint'(signed'(a)) * longint'(65536 - f) + longint'(signed'(b)) * longint'(f);
    return 32'(s >>> 16);
  endfunction

  function automatic out_item_t sample_at(bit [31:0] t);
    out_item_t   r;
    int unsigned n, lo, c, half, p, hi;
    bit [63:0]   q;
    bit [31:0]   f;
    r = '0;
    f = 0;
    lo = 0;
    n = (key_count_q > MaxKeys) ? MaxKeys : key_count_q;
    if (n >= 1) begin
      if (n >= 2) begin
        hi = 0;
        c = n;
        while (c > 0) begin
          half = c / 2;
          p = hi + half;
          if (p < MaxKeys && !(t < time_tbl[p])) begin
            hi = p + 1;
            c -= half + 1;
          end else begin
            c = half;
          end
        end
        if (hi == 0) begin
          lo = 0;
        end else if (hi >= n) begin
          lo = n - 1;
        end else begin
          lo = hi - 1;
          if (time_tbl[hi] > time_tbl[lo] && t >= time_tbl[lo]) begin
            q = {16'b0, t - time_tbl[lo], 16'b0} / {32'b0, time_tbl[hi] - time_tbl[lo]};
            f = (q > 65535) ? 65535 : q[31:0];
          end
        end
      end
      if (step_mode_q || lo + 1 >= n) begin
        r.out_x = x_tbl[lo];
        r.out_y = y_tbl[lo];
        r.out_z = z_tbl[lo];
      end else begin
        r.out_x = blend_val(x_tbl[lo], x_tbl[lo+1], f);
        r.out_y = blend_val(y_tbl[lo], y_tbl[lo+1], f);
        r.out_z = blend_val(z_tbl[lo], z_tbl[lo+1], f);
      end
    end
    r.lower_key = lo[5:0];
    r.blend_fraction = f[15:0];
    return r;
  endfunction

  function automatic void accept_item(in_item_t it);
    if (it.kind == KindLoad) begin
      time_tbl[it.key_index] = it.key_time;
      x_tbl[it.key_index] = it.key_x;
      y_tbl[it.key_index] = it.key_y;
      z_tbl[it.key_index] = it.key_z;
    end else begin
      sample_q.push_back(sample_at(it.query_time));
    end
  endfunction

  // driver: bursts of transfers with random gaps
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      burst_left <= 4;
      gap_left <= 0;
    end else begin
      if (start && !busy) accept_item(item_i);
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pend_q.size() > 0) begin
          item_i <= pend_q.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            case ($urandom_range(0, 3))
              0: gap_left <= 0;
              1: gap_left <= $urandom_range(1, 100);
              default: gap_left <= $urandom_range(1, 12);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sample_q.size() == 0) begin
        $error("unexpected result %h", result_o);
        errors++;
      end else begin
        out_item_t e;
        e = sample_q.pop_front();
        if (result_o.out_x !== e.out_x) begin
          $error("out_x exp %h got %h", e.out_x, result_o.out_x);
          errors++;
        end
        if (result_o.out_y !== e.out_y) begin
          $error("out_y exp %h got %h", e.out_y, result_o.out_y);
          errors++;
        end
        if (result_o.out_z !== e.out_z) begin
          $error("out_z exp %h got %h", e.out_z, result_o.out_z);
          errors++;
        end
        if (result_o.lower_key !== e.lower_key) begin
          $error("lower_key exp %0d got %0d", e.lower_key, result_o.lower_key);
          errors++;
        end
        if (result_o.blend_fraction !== e.blend_fraction) begin
          $error("blend_fraction exp %h got %h", e.blend_fraction, result_o.blend_fraction);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_load(bit [5:0] idx, bit [31:0] t, bit [31:0] x, bit [31:0] y,
                           bit [31:0] z);
    in_item_t it;
    it = '0;
    it.kind = KindLoad;
    it.key_index = idx;
    it.key_time = t;
    it.key_x = x;
    it.key_y = y;
    it.key_z = z;
    gen_time[idx] = t;
    pend_q.push_back(it);
  endtask

  task automatic push_query(bit [31:0] t);
    in_item_t it;
    it = '0;
    it.kind = KindQuery;
    it.key_index = 6'($urandom);
    it.key_time = $urandom;
    it.key_x = $urandom;
    it.key_y = $urandom;
    it.key_z = $urandom;
    it.query_time = t;
    pend_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || start || sample_q.size() > 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, bit [6:0] d);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegKeyCount) key_count_q = d;
    else step_mode_q = d[0];
  endtask

  task automatic load_table(int shape);
    bit [31:0] t, stp;
    t = $urandom_range(0, 1000);
    for (int i = 0; i < MaxKeys; i++) begin
      if (shape == 0) t = $urandom;
      push_load(6'(i), t, $urandom, $urandom, $urandom);
      case ($urandom_range(0, 5))
        0: stp = 0;
        1: stp = $urandom_range(1, 16);
        2: stp = $urandom_range(1, 32'h3F0_0000);
        default: stp = $urandom_range(1, 32'h2_0000);
      endcase
      t += stp;
    end
  endtask

  task automatic query_near(int cnt);
    int k;
    bit [31:0] t;
    for (int i = 0; i < cnt; i++) begin
      k = $urandom_range(0, MaxKeys - 1);
      case ($urandom_range(0, 7))
        0: t = $urandom;
        1: t = gen_time[k];
        2: t = 0;
        3: t = 32'hFFFF_FFFF;
        default: t = gen_time[k] + $urandom_range(0, 32'h4_0000);
      endcase
      push_query(t);
    end
  endtask

  initial begin
    cfg_valid <= 1'b0;
    cfg_index_i <= RegKeyCount;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < MaxKeys; i++) begin
      push_load(6'(i), 32'h1_0000 * (i + 1), 32'h8000_0000 ^ i, 32'h7FFF_FFFF - i, i << 16);
    end
    gen_time[2] = gen_time[1];
    push_load(6'd2, gen_time[1], 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_load(6'd63, 32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    wait_idle();
    write_reg(RegKeyCount, 7'd4);
    write_reg(RegStepMode, 7'd0);
    push_query(0);
    push_query(32'h1_0000);
    push_query(32'h1_8000);
    push_query(32'h2_0000);
    push_query(32'h3_4000);
    push_query(32'h4_0000);
    push_query(32'hFFFF_FFFF);
    wait_idle();
    write_reg(RegStepMode, 7'd1);
    push_query(32'h1_8000);
    push_query(32'h3_C000);
    wait_idle();
    write_reg(RegKeyCount, 7'd0);
    push_query(32'h2_0000);
    wait_idle();
    write_reg(RegKeyCount, 7'd1);
    push_query(0);
    push_query(32'hFFFF_FFFF);
    wait_idle();
    write_reg(RegKeyCount, 7'd127);
    write_reg(RegStepMode, 7'd0);
    push_query(32'hFFFF_0000);
    push_query(32'h20_8000);
    push_query(32'hFFFF_FFFF);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      load_table(($urandom_range(0, 4) == 0) ? 0 : 1);
      wait_idle();
      case (ph)
        0: write_reg(RegKeyCount, 7'd64);
        1: write_reg(RegKeyCount, 7'd2);
        2: write_reg(RegKeyCount, 7'd127);
        3: write_reg(RegKeyCount, 7'd65);
        default: write_reg(RegKeyCount, 7'($urandom_range(0, 127)));
      endcase
      write_reg(RegStepMode, 7'($urandom_range(0, 1)));
      query_near(70);
      for (int i = 0; i < 5; i++) begin
        push_load(6'($urandom_range(0, MaxKeys - 1)), $urandom, $urandom, $urandom, $urandom);
      end
      query_near(10);
      wait_idle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
